// ===== rtl/drh_pkg.sv =====
package drh_pkg;

   // Field widths
   localparam int LIMB_BITS    = 32;
   localparam int LIMBS        = 6;
   localparam int KEEP_LIMBS   = 3;
   localparam int MANT_BITS    = LIMB_BITS * LIMBS;
   localparam int KEEP_BITS    = LIMB_BITS * KEEP_LIMBS;
   localparam int EXP_IN_BITS  = 6;
   localparam int EXP_OUT_BITS = 5;
   localparam int DIGIT_BITS   = 4;
   localparam int IDX_BITS     = 3;

   // Mantissa bits that count; the rest of the input word is ignored
   localparam int WIDE_BITS = 192;
   localparam logic [MANT_BITS-1:0] WIDE_MASK = {MANT_BITS{1'b1}} >> (MANT_BITS - WIDE_BITS);

   // Largest exponent the result may carry
   localparam logic [EXP_IN_BITS-1:0] MAX_SCALE = EXP_IN_BITS'(28);

   // Divide by ten: q = (x * DIV_MAGIC) >> DIV_SHIFT, exact for x < 10 * 2^32
   localparam int CUR_BITS  = LIMB_BITS + DIGIT_BITS;
   localparam int DIV_SHIFT = 39;
   localparam logic [CUR_BITS-1:0] DIV_MAGIC = CUR_BITS'(64'h0000_000C_CCCC_CCCD);

   localparam logic [DIGIT_BITS-1:0] HALF_DIGIT = DIGIT_BITS'(5);

   typedef struct packed {
      logic [63:0]             mant_w2;
      logic [63:0]             mant_w1;
      logic [63:0]             mant_w0;
      logic [EXP_IN_BITS-1:0]  exponent_in;
   } req_type;

   typedef struct packed {
      logic [63:0]             res_low;
      logic [31:0]             res_high;
      logic [EXP_OUT_BITS-1:0] exponent_out;
      logic                    overflow;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic ack;
   } drh_ctrl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } drh_status_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_ROUND = 5'b01000,
      ST_DONE  = 5'b10000
   } drh_state_type;

endpackage

// ===== rtl/drh_div10.sv =====
// One long-division step by ten: {remainder, limb} / 10
module drh_div10
   import drh_pkg::*;
(
   input  logic [DIGIT_BITS-1:0] rem_i,
   input  logic [LIMB_BITS-1:0]  limb_i,
   output logic [LIMB_BITS-1:0]  quot_o,
   output logic [DIGIT_BITS-1:0] rem_o
);

   logic [CUR_BITS-1:0]   cur;
   logic [2*CUR_BITS-1:0] prod;
   logic [CUR_BITS-1:0]   times_ten;
   logic [CUR_BITS-1:0]   diff;

   always_comb begin
      cur       = {rem_i, limb_i};
      prod      = cur * DIV_MAGIC;
      quot_o    = prod[DIV_SHIFT +: LIMB_BITS];
      times_ten = (CUR_BITS'(quot_o) << 3) + (CUR_BITS'(quot_o) << 1);
      diff      = cur - times_ten;
      rem_o     = diff[DIGIT_BITS-1:0];
   end

endmodule

// ===== rtl/drh_seq.sv =====
// Scaling sequencer: checks, divides limb by limb, rounds
module drh_seq
   import drh_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  drh_ctrl_type   ctrl,
   input  req_type        req_data,
   output drh_status_type status,
   output rsp_type        result
);

   drh_state_type                     state_ff, state_in;
   logic [LIMBS-1:0][LIMB_BITS-1:0]   mant_ff, mant_in;
   logic [EXP_IN_BITS-1:0]            exp_ff, exp_in;
   logic [DIGIT_BITS-1:0]             digit_ff, digit_in;
   logic [DIGIT_BITS-1:0]             rem_ff, rem_in;
   logic [IDX_BITS-1:0]               idx_ff, idx_in;
   logic                              sticky_ff, sticky_in;
   logic                              ovf_ff, ovf_in;

   logic [MANT_BITS-1:0]              wide;
   logic                              too_wide;
   logic                              round_up;
   logic [KEEP_BITS:0]                sum;
   logic [LIMB_BITS-1:0]              div_q;
   logic [DIGIT_BITS-1:0]             div_r;

   drh_div10 u_div10 (
      .rem_i  (rem_ff),
      .limb_i (mant_ff[idx_ff]),
      .quot_o (div_q),
      .rem_o  (div_r)
   );

   always_comb begin
      wide     = {req_data.mant_w2, req_data.mant_w1, req_data.mant_w0} & WIDE_MASK;
      too_wide = |mant_ff[LIMBS-1:KEEP_LIMBS];
      round_up = (digit_ff > HALF_DIGIT) ||
                 ((digit_ff == HALF_DIGIT) && (sticky_ff || mant_ff[0][0]));
      sum      = {1'b0, mant_ff[KEEP_LIMBS-1:0]} + (KEEP_BITS+1)'(1);

      state_in  = state_ff;
      mant_in   = mant_ff;
      exp_in    = exp_ff;
      digit_in  = digit_ff;
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      sticky_in = sticky_ff;
      ovf_in    = ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               mant_in   = wide;
               exp_in    = req_data.exponent_in;
               digit_in  = '0;
               sticky_in = 1'b0;
               ovf_in    = 1'b0;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (too_wide || (exp_ff > MAX_SCALE)) begin
               if (exp_ff == '0) begin
                  ovf_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  sticky_in = sticky_ff | (digit_ff != '0);
                  rem_in    = '0;
                  idx_in    = IDX_BITS'(LIMBS - 1);
                  state_in  = ST_DIV;
               end
            end else begin
               state_in = ST_ROUND;
            end
         end
         ST_DIV: begin
            mant_in[idx_ff] = div_q;
            rem_in          = div_r;
            if (idx_ff == '0) begin
               digit_in = div_r;
               exp_in   = exp_ff - EXP_IN_BITS'(1);
               state_in = ST_CHECK;
            end else begin
               idx_in = idx_ff - IDX_BITS'(1);
            end
         end
         ST_ROUND: begin
            if (round_up) begin
               if (sum[KEEP_BITS]) begin
                  ovf_in = 1'b1;
               end else begin
                  mant_in[KEEP_LIMBS-1:0] = sum[KEEP_BITS-1:0];
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ctrl.ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mant_ff   <= mant_in;
      exp_ff    <= exp_in;
      digit_ff  <= digit_in;
      rem_ff    <= rem_in;
      idx_ff    <= idx_in;
      sticky_ff <= sticky_in;
      ovf_ff    <= ovf_in;
   end

   always_comb begin
      status.idle         = (state_ff == ST_IDLE);
      status.done         = (state_ff == ST_DONE);
      result.overflow     = ovf_ff;
      result.res_low      = ovf_ff ? '0 : {mant_ff[1], mant_ff[0]};
      result.res_high     = ovf_ff ? '0 : mant_ff[2];
      result.exponent_out = ovf_ff ? '0 : exp_ff[EXP_OUT_BITS-1:0];
   end

endmodule

// ===== rtl/decimal_round_half_even_to_96bit_core.sv =====
// Decimal round-half-to-even down to a 96-bit mantissa. A request carries a
// 192-bit unsigned mantissa and a power-of-ten exponent (0..63). The core
// drops one decimal digit at a time (divide by ten, exponent minus one) until
// the mantissa fits 96 bits and the exponent is at most 28, then rounds half
// to even using the last dropped digit plus a sticky bit for all earlier
// nonzero digits. Overflow is set, with all other fields zero, when the
// exponent hits zero while the mantissa is still too wide, or when rounding
// carries out of bit 95. The core takes one request at a time. For each
// dropped digit the core runs one range check plus one pass of a single
// 36-bit divide-by-ten step per 32-bit mantissa limb, walking the six limbs
// from the top down; after the last range check comes the rounding step, and
// the result is handed to the output register once that register is not
// held by rsp_stall. At most 63 digits are dropped (bounded by the input
// exponent); a 192-bit mantissa at a large exponent typically needs about 35.
// req_stall is high while the sequencer works; the response register lets a
// new request start while the previous response is still waiting.
module decimal_round_half_even_to_96bit_core
   import drh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,

   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,

   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   drh_ctrl_type   ctrl;
   drh_status_type status;
   rsp_type        result;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    out_free;

   drh_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_data (req_data),
      .status   (status),
      .result   (result)
   );

   always_comb begin
      // output register is free when empty or being drained this cycle
      out_free   = !rsp_valid_ff || !rsp_stall;
      req_stall  = !status.idle;
      ctrl.start = req_valid && status.idle;
      ctrl.ack   = status.done && out_free;

      rsp_valid_in = ctrl.ack || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = ctrl.ack ? result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
